FILE: rtl/core/bbk_pkg.sv
// ---------------------------------------------------------------------------
// bbk_pkg: shared types and constants of the bounded best-k sorted buffer
// Entry layout, operation and result codes, controller states and widths.
// ---------------------------------------------------------------------------
package bbk_pkg;

    // Built store size and stored handle width
    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 16;

    // Field widths on the ports
    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 3;
    localparam int CFG_W    = 5;

    // Derived widths
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int HB_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DRAINED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd5;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HB_W-1:0]  handle;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_FULL_CHK,
        ST_FULL_SHIFT,
        ST_EMIT,
        ST_RESP
    } state_t;

endpackage

FILE: rtl/core/bounded_best_k_sorted_buffer.sv
// ---------------------------------------------------------------------------
// bounded_best_k_sorted_buffer: sorted store of the best (key, handle) pairs
// Keeps entries ordered worst (largest key) first in a one-port-read,
// one-port-write RAM; inserts by read-compare-shift, drains one per cycle while
// the m_ side takes them.
//   channel   dir  tdata                          tuser        tlast
//   s_        in   key[31:0], handle[47:32]       op[1:0]      -
//   m_        out  out_handle[15:0], key[47:16]   kind[2:0]    last
//   cfg_      in   capacity_in_use[4:0]           -            -
//
// An insert reads the RAM and moves each smaller-keyed entry up one place until
// its slot is found; on a full store it first checks the worst entry and, when
// that one is evicted, moves worse entries down over its slot. Each step pairs a
// registered RAM read with a write on the single write port. Drain or clear: one
// entry per cycle through the read port while the m_ side is free; an empty store
// gives a single result. The next transfer can be taken in the cycle after the last.
// A stalled m_ side holds the controller in place; no new transfer is taken
// until the current item's results are all loaded.
// aresetn empties the store (count to zero); RAM contents need no reset.
// ---------------------------------------------------------------------------
module bounded_best_k_sorted_buffer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [bbk_pkg::CFG_W-1:0]     cfg_wdata,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // key[31:0], handle[47:32]
    input  logic [bbk_pkg::OP_W-1:0]      s_tuser,   // op[1:0]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // out_handle[15:0], out_key[47:16]
    output logic [bbk_pkg::KIND_W-1:0]    m_tuser,   // kind[2:0]
    output logic                          m_tlast
);
    import bbk_pkg::*;

    // Entry RAM
    entry_t               mem [CAPACITY];
    entry_t               rd_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    entry_t               mem_wd;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_ra;

    // Control and data registers
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CFG_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HB_W-1:0]      handle_reg, handle_next;
    logic [KIND_W-1:0]    emit_kind_reg, emit_kind_next;
    logic [KIND_W-1:0]    res_kind_reg, res_kind_next;
    logic [HB_W-1:0]      res_handle_reg, res_handle_next;
    logic [KEY_W-1:0]     res_key_reg, res_key_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [HB_W-1:0]      m_handle_reg, m_handle_next;
    logic [KEY_W-1:0]     m_key_reg, m_key_next;
    logic                 m_last_reg, m_last_next;

    // Decoded input and helpers
    logic [OP_W-1:0]      in_op;
    logic [KEY_W-1:0]     in_key;
    logic [HB_W-1:0]      in_handle;
    logic [CNT_W-1:0]     cap_eff;
    logic                 is_full;
    logic                 slot_free;
    logic                 s_fire;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     idx_inc;
    logic                 key_gt_rd;
    logic                 key_lt_rd;
    entry_t               new_entry;

    assign in_op     = s_tuser;
    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_handle = s_tdata[KEY_W +: HB_W];

    // Effective capacity, saturated to 1..CAPACITY
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(CAPACITY)) begin
            cap_eff = CNT_W'(CAPACITY);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign is_full   = (count_reg >= cap_eff);
    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign key_gt_rd = $signed(key_reg) > $signed(rd_reg.key);
    assign key_lt_rd = $signed(key_reg) < $signed(rd_reg.key);
    assign new_entry = '{key: key_reg, handle: handle_reg};

    // RAM: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_ra];
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CFG_W'(16);
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        emit_kind_reg  <= emit_kind_next;
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_key_reg    <= res_key_next;
        m_kind_reg     <= m_kind_next;
        m_handle_reg   <= m_handle_next;
        m_key_reg      <= m_key_next;
        m_last_reg     <= m_last_next;
    end

    // Next state, RAM accesses and result loading
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        emit_kind_next  = emit_kind_reg;
        res_kind_next   = res_kind_reg;
        res_handle_next = res_handle_reg;
        res_key_next    = res_key_reg;
        m_kind_next     = m_kind_reg;
        m_handle_next   = m_handle_reg;
        m_key_next      = m_key_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = new_entry;
        mem_re          = 1'b0;
        mem_ra          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    key_next    = in_key;
                    handle_next = in_handle;
                    case (in_op)
                        OP_INSERT: begin
                            if (!is_full) begin
                                res_kind_next   = KIND_STORED;
                                res_handle_next = '0;
                                res_key_next    = '0;
                                if (count_reg == '0) begin
                                    // empty store: write straight to the bottom
                                    mem_we     = 1'b1;
                                    mem_wa     = '0;
                                    mem_wd     = '{key: in_key, handle: in_handle};
                                    count_next = CNT_W'(1);
                                    state_next = ST_RESP;
                                end else begin
                                    mem_re     = 1'b1;
                                    mem_ra     = ADDR_W'(count_reg - CNT_W'(1));
                                    idx_next   = count_reg;
                                    state_next = ST_INS_SHIFT;
                                end
                            end else begin
                                // full: look at the worst entry first
                                mem_re     = 1'b1;
                                mem_ra     = '0;
                                state_next = ST_FULL_CHK;
                            end
                        end
                        OP_DRAIN, OP_CLEAR: begin
                            emit_kind_next = (in_op == OP_DRAIN) ? KIND_DRAINED
                                                                 : KIND_CLEARED;
                            if (count_reg == '0) begin
                                res_kind_next   = KIND_EMPTY;
                                res_handle_next = '0;
                                res_key_next    = '0;
                                state_next      = ST_RESP;
                            end else begin
                                mem_re     = 1'b1;
                                mem_ra     = '0;
                                idx_next   = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        default: begin
                            // unused op: no result, no change
                        end
                    endcase
                end
            end

            // Move smaller-keyed entries up one place until the slot is found
            ST_INS_SHIFT: begin
                if (idx_reg == '0 || !key_gt_rd) begin
                    mem_we     = 1'b1;
                    mem_wa     = idx_reg[ADDR_W-1:0];
                    mem_wd     = new_entry;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_RESP;
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = idx_reg[ADDR_W-1:0];
                    mem_wd   = rd_reg;
                    idx_next = idx_dec;
                    if (idx_dec != '0) begin
                        mem_re = 1'b1;
                        mem_ra = ADDR_W'(idx_dec - CNT_W'(1));
                    end
                end
            end

            // Full store: reject unless strictly better than the worst
            ST_FULL_CHK: begin
                if (!key_lt_rd) begin
                    res_kind_next   = KIND_REJECTED;
                    res_handle_next = handle_reg;
                    res_key_next    = key_reg;
                    state_next      = ST_RESP;
                end else begin
                    res_kind_next   = KIND_EVICTED;
                    res_handle_next = rd_reg.handle;
                    res_key_next    = rd_reg.key;
                    idx_next        = CNT_W'(1);
                    if (count_reg > CNT_W'(1)) begin
                        mem_re = 1'b1;
                        mem_ra = ADDR_W'(1);
                    end
                    state_next = ST_FULL_SHIFT;
                end
            end

            // Move worse-than-new (larger-key) entries down over the evicted slot
            ST_FULL_SHIFT: begin
                if (idx_reg >= count_reg || !key_lt_rd) begin
                    mem_we     = 1'b1;
                    mem_wa     = ADDR_W'(idx_dec);
                    mem_wd     = new_entry;
                    state_next = ST_RESP;
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = ADDR_W'(idx_dec);
                    mem_wd   = rd_reg;
                    idx_next = idx_inc;
                    if (idx_inc < count_reg) begin
                        mem_re = 1'b1;
                        mem_ra = ADDR_W'(idx_inc);
                    end
                end
            end

            // Drain or clear: one entry per cycle while the output slot is free, worst first
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = emit_kind_reg;
                    m_handle_next = rd_reg.handle;
                    m_key_next    = rd_reg.key;
                    m_last_next   = (idx_inc == count_reg);
                    if (idx_inc == count_reg) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_inc;
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(idx_inc);
                    end
                end
            end

            // Single result of an insert or an empty drain or clear
            ST_RESP: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_handle_next = res_handle_reg;
                    m_key_next    = res_key_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_key_reg, HANDLE_W'(m_handle_reg)};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: bench/bbk_checker.sv
// ---------------------------------------------------------------------------
// bbk_checker: scoreboard for the bounded best-k sorted buffer
// Watches the configuration port and both stream channels. Keeps its own
// sorted copy of the store, works out the results of every transfer taken on
// the s_ side and compares each m_ transfer, field by field, with the oldest
// outstanding result.
// ---------------------------------------------------------------------------
module bbk_checker
    import bbk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [47:0]          s_tdata,   // key[31:0], handle[47:32]
    input  logic [OP_W-1:0]      s_tuser,   // op[1:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,   // out_handle[15:0], out_key[47:16]
    input  logic [KIND_W-1:0]    m_tuser,   // kind[2:0]
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic                last;
    } outcome_t;

    // mirror of the store, worst entry at index 0
    logic signed [KEY_W-1:0] ranked_keys    [CAPACITY];
    logic [HANDLE_W-1:0]     ranked_handles [CAPACITY];
    int unsigned             ranked_count;
    logic [CFG_W-1:0]        cap_reg;

    // results still owed by the block, oldest first
    outcome_t                owed_results [$];

    function automatic void owe_result(input logic [KIND_W-1:0] kind,
                                       input logic [HANDLE_W-1:0] handle,
                                       input logic [KEY_W-1:0] key,
                                       input logic last);
        outcome_t r;
        r.kind   = kind;
        r.handle = handle;
        r.key    = key;
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    // drain and clear: every entry worst to best, or one empty marker
    function automatic void flush_store(input logic [KIND_W-1:0] kind);
        if (ranked_count == 0) begin
            owe_result(KIND_EMPTY, '0, '0, 1'b1);
        end else begin
            for (int i = 0; i < ranked_count; i++)
                owe_result(kind, ranked_handles[i], ranked_keys[i], i == ranked_count - 1);
        end
        ranked_count = 0;
    endfunction

    // sorted insert with eviction of the worst entry once full
    function automatic void insert_entry(input logic signed [KEY_W-1:0] key,
                                         input logic [HANDLE_W-1:0] handle);
        int unsigned limit;
        int unsigned pos;
        limit = (cap_reg == 0) ? 1 : (cap_reg > CAPACITY) ? CAPACITY : cap_reg;
        if (ranked_count < limit) begin
            // room left: goes behind every equal key
            pos = ranked_count;
            while (pos > 0 && key > ranked_keys[pos-1]) begin
                ranked_keys[pos]    = ranked_keys[pos-1];
                ranked_handles[pos] = ranked_handles[pos-1];
                pos--;
            end
            ranked_keys[pos]    = key;
            ranked_handles[pos] = handle;
            ranked_count++;
            owe_result(KIND_STORED, '0, '0, 1'b1);
        end else if (!(key < ranked_keys[0])) begin
            owe_result(KIND_REJECTED, handle, key, 1'b1);
        end else begin
            // full (or over a lowered capacity): worst leaves, count unchanged
            owe_result(KIND_EVICTED, ranked_handles[0], ranked_keys[0], 1'b1);
            pos = 1;
            while (pos < ranked_count && key < ranked_keys[pos]) begin
                ranked_keys[pos-1]    = ranked_keys[pos];
                ranked_handles[pos-1] = ranked_handles[pos];
                pos++;
            end
            ranked_keys[pos-1]    = key;
            ranked_handles[pos-1] = handle;
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            ranked_count = 0;
            cap_reg      = CFG_W'(16);
            owed_results.delete();
            mismatches   = 0;
        end else begin
            if (cfg_we)
                cap_reg = cfg_wdata;

            // input transfer: predict its results
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_INSERT: insert_entry(s_tdata[31:0], s_tdata[47:32]);
                    OP_DRAIN:  flush_store(KIND_DRAINED);
                    OP_CLEAR:  flush_store(KIND_CLEARED);
                    default: ;  // unused op code does nothing
                endcase
            end

            // result transfer: compare against the oldest owed result
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.handle = m_tdata[15:0];
                got.key    = m_tdata[47:16];
                got.last   = m_tlast;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got kind %0d handle %h key %h last %b"},
                             $time, got.kind, got.handle, got.key, got.last);
                end else begin
                    want = owed_results.pop_front();
                    if (got.kind !== want.kind || got.handle !== want.handle ||
                        got.key !== want.key || got.last !== want.last) begin
                        mismatches++;
                        $display({"%0t: result mismatch, ",
                                  "expected kind %0d handle %h key %h last %b, ",
                                  "got kind %0d handle %h key %h last %b"},
                                 $time, want.kind, want.handle, want.key, want.last,
                                 got.kind, got.handle, got.key, got.last);
                    end
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: regression for the bounded best-k sorted buffer
// Drives directed cases (empty store, key extremes, ties, single slot,
// saturating and lowered capacity) and then random phases of inserts with
// drains and clears, under bursty input and a stalling result side. The
// checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbk_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    localparam int RANDOM_ITEMS   = 120;
    localparam int SETTLE_CYCLES  = 24;      // longest drain plus output register
    localparam int SQUEEZE_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum int {FLOW_OPEN, FLOW_MOSTLY, FLOW_SPARSE, FLOW_TOGGLE} flow_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    int                  mismatches;
    int                  outstanding;
    int                  burst_left;
    int                  cycle_count;
    bit                  squeeze_req;

    bounded_best_k_sorted_buffer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bbk_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: changing stall patterns, one long hold-off on request
    initial begin
        flow_t mode;
        int    left;
        bit    squeezed;
        m_tready = 1'b0;
        mode     = FLOW_OPEN;
        left     = 0;
        squeezed = 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = flow_t'($urandom_range(0, 3));
                left = $urandom_range(4, 64);
            end
            left--;
            case (mode)
                FLOW_OPEN:   m_tready <= 1'b1;
                FLOW_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                FLOW_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ~m_tready;
            endcase
        end
    end

    // one transfer on the s_ side, with bursts and gaps between them
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] handle);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every owed result has come back and the block has settled
    task automatic wait_quiet;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int               random_sent;
        int               cap;
        int               eff;
        int               n_ops;
        int               roll;
        bit               tie_heavy;
        logic [KEY_W-1:0] k;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_INSERT;
        burst_left  = 0;
        cycle_count = 0;
        squeeze_req = 1'b0;
        random_sent = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty store: drain, clear, unused op
        send_item(OP_DRAIN,   32'h0000_0000, 16'h0000);
        send_item(OP_CLEAR,   32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_IGNORED, 32'h1234_5678, 16'hABCD);

        // key extremes and a tie, then drain in order
        send_item(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(OP_INSERT, 32'h8000_0000, 16'h0000);
        send_item(OP_INSERT, 32'h0000_0000, 16'h1111);
        send_item(OP_INSERT, 32'h0000_0000, 16'h2222);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 16'h3333);
        send_item(OP_DRAIN,  32'h0000_0000, 16'h0000);

        // single slot: equal key rejected, smaller evicts
        write_capacity(CFG_W'(1));
        send_item(OP_INSERT, 32'd5,          16'h0001);
        send_item(OP_INSERT, 32'd5,          16'h0002);
        send_item(OP_INSERT, 32'd4,          16'h0003);
        send_item(OP_INSERT, 32'h8000_0000,  16'h0004);
        send_item(OP_INSERT, 32'h7FFF_FFFF,  16'h0005);
        send_item(OP_CLEAR,  32'h0000_0000,  16'h0000);

        // zero saturates to one
        write_capacity(CFG_W'(0));
        send_item(OP_INSERT, 32'd10, 16'h0006);
        send_item(OP_INSERT, 32'd9,  16'h0007);

        // top value saturates to the built size
        write_capacity(CFG_W'(31));
        send_item(OP_INSERT, 32'd3,           16'h0008);
        send_item(OP_INSERT, 32'd20,          16'h0009);
        send_item(OP_INSERT, 32'hFFFF_FFF9,   16'h000A);
        send_item(OP_INSERT, 32'd3,           16'h000B);

        // capacity lowered below the count: store counts as full
        write_capacity(CFG_W'(2));
        send_item(OP_INSERT, 32'd15,  16'h000C);
        send_item(OP_INSERT, 32'd100, 16'h000D);
        send_item(OP_DRAIN,  32'h0,   16'h0000);

        // random phases, each under its own capacity
        while (random_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 7);
            case (roll)
                0:       cap = 1;
                1:       cap = 16;
                2:       cap = 0;
                3:       cap = $urandom_range(17, 31);
                default: cap = $urandom_range(2, 15);
            endcase
            write_capacity(CFG_W'(cap));
            squeeze_req = 1'b1;
            eff       = (cap < 1) ? 1 : (cap > CAPACITY) ? CAPACITY : cap;
            n_ops     = $urandom_range(eff / 2, eff + 8);
            tie_heavy = 1'($urandom_range(0, 1));
            for (int j = 0; j < n_ops; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    send_item(OP_IGNORED, $urandom(), HANDLE_W'($urandom()));
                end else if (roll < 7) begin
                    send_item($urandom_range(0, 1) ? OP_DRAIN : OP_CLEAR, $urandom(),
                              HANDLE_W'($urandom()));
                    random_sent++;
                end else begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0)
                        k = 32'h7FFF_FFFF;
                    else if (roll == 1)
                        k = 32'h8000_0000;
                    else if (tie_heavy || roll < 4)
                        k = $urandom_range(0, 6) - 3;
                    else
                        k = $urandom();
                    send_item(OP_INSERT, k, HANDLE_W'($urandom()));
                    random_sent++;
                end
            end
            // most phases end empty; some carry entries into the next setting
            if ($urandom_range(0, 3) != 0) begin
                send_item($urandom_range(0, 1) ? OP_DRAIN : OP_CLEAR, $urandom(),
                          HANDLE_W'($urandom()));
                random_sent++;
            end
        end

        s_tvalid <= 1'b0;
        wait_quiet();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bbk_pkg.sv
rtl/core/bounded_best_k_sorted_buffer.sv
bench/bbk_checker.sv
bench/testbench.sv
